/* hw/rtl/mesh_vertex_normals_unit_defines.svh */
// assertion macros for the mesh vertex normals unit
// included by the rtl files that carry concurrent assertions
`ifndef MESH_VERTEX_NORMALS_UNIT_DEFINES_SVH
`define MESH_VERTEX_NORMALS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MVN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("mvn invariant violated");
`define MVN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mvn implication violated");
`else
`define MVN_ASSERT(lbl, clk, rstn, prop)
`define MVN_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/mvn_pkg.sv */
// shared types and constants for the mesh vertex normals unit
// no dependencies
`default_nettype none
package mvn_pkg;
    localparam int VTX_DEPTH = 1024;
    localparam int VIDX_W    = $clog2(VTX_DEPTH);
    localparam int VCNT_W    = VIDX_W + 1;
    localparam int TRI_DEPTH = 2048;
    localparam int TIDX_W    = $clog2(TRI_DEPTH);
    localparam int TCNT_W    = TIDX_W + 1;
    localparam int CORNER_W  = 10;
    localparam int SLOT_W    = 11;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int TERM_W    = PROD_W + 1;
    localparam int MAG_W     = 65;
    localparam int NORM_W    = 16;
    localparam int ACC_W     = 27;

    typedef enum logic [1:0] {
        MODE_VERTEX = 2'd0,
        MODE_TRI    = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                       mode;
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic signed [COORD_W-1:0]   pos_z;
        logic [CORNER_W-1:0]         corner_a;
        logic [CORNER_W-1:0]         corner_b;
        logic [CORNER_W-1:0]         corner_c;
        logic [CORNER_W-1:0]         query_vertex;
    } cmd_t;

    typedef struct packed {
        status_t                     status;
        logic [SLOT_W-1:0]           slot;
        logic signed [NORM_W-1:0]    normal_x;
        logic signed [NORM_W-1:0]    normal_y;
        logic signed [NORM_W-1:0]    normal_z;
    } rsp_t;

    // sign and magnitude of three vector components
    typedef struct packed {
        logic [2:0]              neg;
        logic [2:0][MAG_W-1:0]   mag;
    } vec_t;

    typedef struct packed {
        logic [2:0][NORM_W-1:0]  comp;
    } nrm_t;
endpackage
`default_nettype wire

/* hw/rtl/mesh_vertex_normals_unit.sv */
// top level of the mesh vertex normals unit: tables, query sequencer, cross products
// depends on mvn_pkg, mvn_unitize and mesh_vertex_normals_unit_defines.svh
//
//   channel | direction | handshake            | word
//   cmd     | in        | cmd_valid/cmd_stall  | mvn_pkg::cmd_t
//   rsp     | out       | rsp_valid/rsp_stall  | mvn_pkg::rsp_t
//
// appends and rejected commands give their registered result word in the cycle after they are accepted
// a query scans every stored triangle; for each triangle that uses the vertex it
// reads the vertices, forms six products on one 33x33 multiplier and runs one pass of
// the iterative unitize unit, and it ends with a final unitize of the sum
// the tables are not cleared by reset; only entries below the counts are read
// cmd_stall is high while a query runs and while a result word waits on rsp_stall
`default_nettype none
`include "mesh_vertex_normals_unit_defines.svh"
module mesh_vertex_normals_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire mvn_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mvn_pkg::rsp_t      rsp
);
    localparam logic [mvn_pkg::VCNT_W-1:0] VCNT_MAX = mvn_pkg::VTX_DEPTH[mvn_pkg::VCNT_W-1:0];
    localparam logic [mvn_pkg::TCNT_W-1:0] TCNT_MAX = mvn_pkg::TRI_DEPTH[mvn_pkg::TCNT_W-1:0];

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_TRD    = 12'b000000000010,
        S_TCHK   = 12'b000000000100,
        S_VA     = 12'b000000001000,
        S_VB     = 12'b000000010000,
        S_VC     = 12'b000000100000,
        S_VD     = 12'b000001000000,
        S_MUL    = 12'b000010000000,
        S_USTART = 12'b000100000000,
        S_UWAIT  = 12'b001000000000,
        S_FSTART = 12'b010000000000,
        S_FWAIT  = 12'b100000000000
    } state_t;

    // table storage
    logic [mvn_pkg::COORD_W-1:0]    vx_mem [mvn_pkg::VTX_DEPTH];
    logic [mvn_pkg::COORD_W-1:0]    vy_mem [mvn_pkg::VTX_DEPTH];
    logic [mvn_pkg::COORD_W-1:0]    vz_mem [mvn_pkg::VTX_DEPTH];
    logic [3*mvn_pkg::CORNER_W-1:0] tri_mem [mvn_pkg::TRI_DEPTH];
    logic [mvn_pkg::COORD_W-1:0]    vx_q, vy_q, vz_q;
    logic [3*mvn_pkg::CORNER_W-1:0] tri_q;
    logic [mvn_pkg::VIDX_W-1:0]     v_addr;

    state_t                          state_reg, state_next;
    logic [mvn_pkg::VCNT_W-1:0]      vcnt_reg, vcnt_next;
    logic [mvn_pkg::TCNT_W-1:0]      tcnt_reg, tcnt_next;
    logic [mvn_pkg::TIDX_W-1:0]      j_reg, j_next;
    logic [mvn_pkg::VIDX_W-1:0]      qv_reg, qv_next;
    logic [mvn_pkg::VIDX_W-1:0]      ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic signed [mvn_pkg::COORD_W-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [mvn_pkg::DIFF_W-1:0]  ux_reg, ux_next, uy_reg, uy_next, uz_reg, uz_next;
    logic signed [mvn_pkg::DIFF_W-1:0]  wx_reg, wx_next, wy_reg, wy_next, wz_reg, wz_next;
    logic [2:0]                      k_reg, k_next;
    logic signed [mvn_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [2:0][mvn_pkg::TERM_W-1:0] term_reg, term_next;
    logic [2:0][mvn_pkg::ACC_W-1:0]  acc_reg, acc_next;
    mvn_pkg::rsp_t                   rsp_reg, rsp_next;
    logic                            rsp_valid_reg, rsp_valid_next;

    logic                            accept;
    logic                            new_rsp;
    logic signed [mvn_pkg::DIFF_W-1:0] op_a, op_b;
    logic [mvn_pkg::TERM_W-1:0]      prod_ext;
    logic [2:0]                      k_prev;
    logic [mvn_pkg::TCNT_W-1:0]      j_ext;
    logic                            last_tri;
    logic                            hit;
    logic [mvn_pkg::VIDX_W-1:0]      t_a, t_b, t_c;
    logic                            uni_start;
    logic                            uni_done;
    mvn_pkg::vec_t                   uni_vec;
    mvn_pkg::nrm_t                   uni_nrm;
    logic [mvn_pkg::TERM_W-1:0]      term_abs [3];
    logic [mvn_pkg::ACC_W-1:0]       acc_abs [3];

    assign cmd_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign j_ext     = {1'b0, j_reg};
    assign last_tri  = (j_ext + 1'b1) == tcnt_reg;
    assign t_a       = tri_q[3*mvn_pkg::CORNER_W-1:2*mvn_pkg::CORNER_W];
    assign t_b       = tri_q[2*mvn_pkg::CORNER_W-1:mvn_pkg::CORNER_W];
    assign t_c       = tri_q[mvn_pkg::CORNER_W-1:0];
    assign hit       = (t_a == qv_reg) || (t_b == qv_reg) || (t_c == qv_reg);
    assign k_prev    = k_reg - 3'd1;
    assign prod_ext  = {prod_reg[mvn_pkg::PROD_W-1], prod_reg};

    // vertex read port address follows the corner being fetched
    always_comb
    begin
        case (state_reg)
            S_VB:    v_addr = cb_reg;
            S_VC:    v_addr = cc_reg;
            default: v_addr = ca_reg;
        endcase
    end

    // multiplier operands, cross product terms in order yz-zy, zx-xz, xy-yx
    always_comb
    begin
        case (k_reg)
            3'd0:    begin op_a = uy_reg; op_b = wz_reg; end
            3'd1:    begin op_a = uz_reg; op_b = wy_reg; end
            3'd2:    begin op_a = uz_reg; op_b = wx_reg; end
            3'd3:    begin op_a = ux_reg; op_b = wz_reg; end
            3'd4:    begin op_a = ux_reg; op_b = wy_reg; end
            default: begin op_a = uy_reg; op_b = wx_reg; end
        endcase
    end

    // sign and magnitude for the unitize unit
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            term_abs[i] = term_reg[i][mvn_pkg::TERM_W-1] ? -term_reg[i] : term_reg[i];
            acc_abs[i]  = acc_reg[i][mvn_pkg::ACC_W-1] ? -acc_reg[i] : acc_reg[i];
            if (state_reg == S_FSTART)
            begin
                uni_vec.neg[i] = acc_reg[i][mvn_pkg::ACC_W-1];
                uni_vec.mag[i] = {{(mvn_pkg::MAG_W-mvn_pkg::ACC_W){1'b0}}, acc_abs[i]};
            end
            else
            begin
                uni_vec.neg[i] = term_reg[i][mvn_pkg::TERM_W-1];
                uni_vec.mag[i] = term_abs[i][mvn_pkg::MAG_W-1:0];
            end
        end
    end

    assign uni_start = (state_reg == S_USTART) || (state_reg == S_FSTART);

    mvn_unitize u_unitize (
        .clk   (clk),
        .rst_n (rst_n),
        .start (uni_start),
        .vec   (uni_vec),
        .done  (uni_done),
        .nrm   (uni_nrm)
    );

    always_comb
    begin
        state_next = state_reg;
        vcnt_next  = vcnt_reg;
        tcnt_next  = tcnt_reg;
        j_next     = j_reg;
        qv_next    = qv_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        cc_next    = cc_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        uz_next    = uz_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        wz_next    = wz_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        term_next  = term_reg;
        acc_next   = acc_reg;
        rsp_next   = rsp_reg;
        new_rsp    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '0;
                    case (cmd.mode)
                        mvn_pkg::MODE_VERTEX:
                        begin
                            new_rsp = 1'b1;
                            if (vcnt_reg >= VCNT_MAX)
                            begin
                                rsp_next.status = mvn_pkg::ST_FULL;
                            end
                            else
                            begin
                                rsp_next.slot = mvn_pkg::SLOT_W'(vcnt_reg);
                                vcnt_next     = vcnt_reg + 1'b1;
                            end
                        end
                        mvn_pkg::MODE_TRI:
                        begin
                            new_rsp = 1'b1;
                            if (tcnt_reg >= TCNT_MAX)
                            begin
                                rsp_next.status = mvn_pkg::ST_FULL;
                            end
                            else if ({1'b0, cmd.corner_a} >= vcnt_reg ||
                                     {1'b0, cmd.corner_b} >= vcnt_reg ||
                                     {1'b0, cmd.corner_c} >= vcnt_reg)
                            begin
                                rsp_next.status = mvn_pkg::ST_RANGE;
                            end
                            else
                            begin
                                rsp_next.slot = mvn_pkg::SLOT_W'(tcnt_reg);
                                tcnt_next     = tcnt_reg + 1'b1;
                            end
                        end
                        mvn_pkg::MODE_QUERY:
                        begin
                            qv_next  = cmd.query_vertex;
                            j_next   = '0;
                            acc_next = '0;
                            if ({1'b0, cmd.query_vertex} >= vcnt_reg)
                            begin
                                new_rsp         = 1'b1;
                                rsp_next.status = mvn_pkg::ST_RANGE;
                                rsp_next.slot   = {1'b0, cmd.query_vertex};
                            end
                            else if (tcnt_reg == '0)
                            begin
                                state_next = S_FSTART;
                            end
                            else
                            begin
                                state_next = S_TRD;
                            end
                        end
                        default:
                        begin
                            new_rsp = 1'b1;
                        end
                    endcase
                end
            end
            S_TRD:
            begin
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                ca_next = t_a;
                cb_next = t_b;
                cc_next = t_c;
                if (hit)
                begin
                    state_next = S_VA;
                end
                else if (last_tri)
                begin
                    state_next = S_FSTART;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_TRD;
                end
            end
            S_VA:
            begin
                state_next = S_VB;
            end
            S_VB:
            begin
                ax_next    = vx_q;
                ay_next    = vy_q;
                az_next    = vz_q;
                state_next = S_VC;
            end
            S_VC:
            begin
                ux_next    = {vx_q[31], vx_q} - {ax_reg[31], ax_reg};
                uy_next    = {vy_q[31], vy_q} - {ay_reg[31], ay_reg};
                uz_next    = {vz_q[31], vz_q} - {az_reg[31], az_reg};
                state_next = S_VD;
            end
            S_VD:
            begin
                wx_next    = {vx_q[31], vx_q} - {ax_reg[31], ax_reg};
                wy_next    = {vy_q[31], vy_q} - {ay_reg[31], ay_reg};
                wz_next    = {vz_q[31], vz_q} - {az_reg[31], az_reg};
                k_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // product k is registered, then folded into its term in the next cycle
                if (k_reg != 3'd6)
                begin
                    prod_next = op_a * op_b;
                end
                if (k_reg != 3'd0)
                begin
                    if (!k_prev[0])
                    begin
                        term_next[k_prev[2:1]] = prod_ext;
                    end
                    else
                    begin
                        term_next[k_prev[2:1]] = term_reg[k_prev[2:1]] - prod_ext;
                    end
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd6)
                begin
                    state_next = S_USTART;
                end
            end
            S_USTART:
            begin
                state_next = S_UWAIT;
            end
            S_UWAIT:
            begin
                if (uni_done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_next[i] = acc_reg[i] + {{(mvn_pkg::ACC_W-mvn_pkg::NORM_W)
                                      {uni_nrm.comp[i][mvn_pkg::NORM_W-1]}}, uni_nrm.comp[i]};
                    end
                    if (last_tri)
                    begin
                        state_next = S_FSTART;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_TRD;
                    end
                end
            end
            S_FSTART:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (uni_done)
                begin
                    new_rsp           = 1'b1;
                    rsp_next.status   = mvn_pkg::ST_OK;
                    rsp_next.slot     = {1'b0, qv_reg};
                    rsp_next.normal_x = uni_nrm.comp[0];
                    rsp_next.normal_y = uni_nrm.comp[1];
                    rsp_next.normal_z = uni_nrm.comp[2];
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rsp_valid_next = (rsp_valid_reg && rsp_stall) || new_rsp;
    end

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == mvn_pkg::MODE_VERTEX && vcnt_reg < VCNT_MAX)
        begin
            vx_mem[vcnt_reg[mvn_pkg::VIDX_W-1:0]] <= cmd.pos_x;
            vy_mem[vcnt_reg[mvn_pkg::VIDX_W-1:0]] <= cmd.pos_y;
            vz_mem[vcnt_reg[mvn_pkg::VIDX_W-1:0]] <= cmd.pos_z;
        end
        vx_q <= vx_mem[v_addr];
        vy_q <= vy_mem[v_addr];
        vz_q <= vz_mem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == mvn_pkg::MODE_TRI && tcnt_reg < TCNT_MAX &&
            {1'b0, cmd.corner_a} < vcnt_reg && {1'b0, cmd.corner_b} < vcnt_reg &&
            {1'b0, cmd.corner_c} < vcnt_reg)
        begin
            tri_mem[tcnt_reg[mvn_pkg::TIDX_W-1:0]] <= {cmd.corner_a, cmd.corner_b, cmd.corner_c};
        end
        tri_q <= tri_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcnt_reg      <= '0;
            tcnt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcnt_reg      <= vcnt_next;
            tcnt_reg      <= tcnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        qv_reg   <= qv_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        cc_reg   <= cc_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        uz_reg   <= uz_next;
        wx_reg   <= wx_next;
        wy_reg   <= wy_next;
        wz_reg   <= wz_next;
        k_reg    <= k_next;
        prod_reg <= prod_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `MVN_ASSERT(a_vcnt_bound, clk, rst_n, vcnt_reg <= VCNT_MAX)
    `MVN_ASSERT(a_tcnt_bound, clk, rst_n, tcnt_reg <= TCNT_MAX)
    `MVN_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_reg == S_TCHK, j_ext < tcnt_reg)
    `MVN_ASSERT_IMPL(a_done_expected, clk, rst_n, uni_done, state_reg == S_UWAIT || state_reg == S_FWAIT)
    `MVN_ASSERT_IMPL(a_no_word_in_query, clk, rst_n, state_reg != S_IDLE, !rsp_valid_reg)
endmodule
`default_nettype wire

/* hw/rtl/mvn_unitize.sv */
// iterative scaling of a three component vector to a q1.14 unit vector
// uses mvn_pkg types
`default_nettype none
module mvn_unitize (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire mvn_pkg::vec_t vec,
    output logic               done,
    output mvn_pkg::nrm_t      nrm
);
    typedef enum logic [5:0] {
        U_IDLE  = 6'b000001,
        U_SHIFT = 6'b000010,
        U_SQ    = 6'b000100,
        U_ROOT  = 6'b001000,
        U_DIV   = 6'b010000,
        U_DONE  = 6'b100000
    } ustate_t;

    ustate_t                          state_reg, state_next;
    logic [2:0]                       neg_reg, neg_next;
    logic [2:0][mvn_pkg::MAG_W-1:0]   mag_reg, mag_next;
    logic [5:0]                       cnt_reg, cnt_next;
    logic [59:0]                      prod_reg, prod_next;
    logic [63:0]                      rem_reg, rem_next;
    logic [63:0]                      res_reg, res_next;
    logic [63:0]                      bit_reg, bit_next;
    logic [30:0]                      len_reg, len_next;
    logic [1:0]                       ci_reg, ci_next;
    logic [30:0]                      r_reg, r_next;
    logic [14:0]                      nb_reg, nb_next;
    logic [14:0]                      q_reg, q_next;
    logic [2:0][mvn_pkg::NORM_W-1:0]  comp_reg, comp_next;
    logic                             done_reg, done_next;

    logic [mvn_pkg::MAG_W-1:0] mag_or;
    logic [mvn_pkg::MAG_W-1:0] sq_sel;
    logic [mvn_pkg::MAG_W-1:0] div_sel;
    logic [63:0]               root_try;
    logic [44:0]               numer;
    logic [31:0]               rr;
    logic                      ge;
    logic [15:0]               q_ext;

    always_comb
    begin
        mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
        sq_sel   = (cnt_reg == 6'd2) ? mag_reg[2] :
                   (cnt_reg == 6'd1) ? mag_reg[1] : mag_reg[0];
        div_sel  = (ci_reg == 2'd2) ? mag_reg[2] :
                   (ci_reg == 2'd1) ? mag_reg[1] : mag_reg[0];
        root_try = res_reg + bit_reg;
        numer    = {1'b0, div_sel[29:0], 14'd0} + {14'd0, 1'b0, len_reg[30:1]};
        rr       = {r_reg, nb_reg[14]};
        ge       = rr >= {1'b0, len_reg};
        q_ext    = {1'b0, q_reg[13:0], ge};
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        ci_next    = ci_reg;
        r_next     = r_reg;
        nb_next    = nb_reg;
        q_next     = q_reg;
        comp_next  = comp_reg;
        done_next  = 1'b0;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    neg_next   = vec.neg;
                    mag_next   = vec.mag;
                    state_next = U_SHIFT;
                end
            end
            U_SHIFT:
            begin
                // one bit of common right shift per cycle until all fit 30 bits
                if (mag_or[mvn_pkg::MAG_W-1:30] != '0)
                begin
                    mag_next[0] = mag_reg[0] >> 1;
                    mag_next[1] = mag_reg[1] >> 1;
                    mag_next[2] = mag_reg[2] >> 1;
                end
                else
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = U_SQ;
                end
            end
            U_SQ:
            begin
                if (cnt_reg != 6'd3)
                begin
                    prod_next = sq_sel[29:0] * sq_sel[29:0];
                end
                if (cnt_reg != 6'd0)
                begin
                    rem_next = rem_reg + {4'd0, prod_reg};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    res_next   = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = U_ROOT;
                end
            end
            U_ROOT:
            begin
                if (bit_reg != '0)
                begin
                    if (rem_reg >= root_try)
                    begin
                        rem_next = rem_reg - root_try;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                else
                begin
                    len_next   = res_reg[30:0];
                    ci_next    = '0;
                    cnt_next   = '0;
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                if (len_reg == '0)
                begin
                    // zero length vector answers zero
                    comp_next  = '0;
                    state_next = U_DONE;
                end
                else if (cnt_reg == 6'd0)
                begin
                    r_next   = {1'b0, numer[44:15]};
                    nb_next  = numer[14:0];
                    q_next   = '0;
                    cnt_next = 6'd1;
                end
                else
                begin
                    r_next   = ge ? 31'(rr - {1'b0, len_reg}) : rr[30:0];
                    q_next   = q_ext[14:0];
                    nb_next  = {nb_reg[13:0], 1'b0};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                    begin
                        comp_next[ci_reg] = neg_reg[ci_reg] ? 16'(-q_ext) : q_ext;
                        cnt_next          = '0;
                        ci_next           = ci_reg + 2'd1;
                        if (ci_reg == 2'd2)
                        begin
                            state_next = U_DONE;
                        end
                    end
                end
            end
            U_DONE:
            begin
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        ci_reg   <= ci_next;
        r_reg    <= r_next;
        nb_reg   <= nb_next;
        q_reg    <= q_next;
        comp_reg <= comp_next;
    end

    assign done     = done_reg;
    assign nrm.comp = comp_reg;
endmodule
`default_nettype wire
